FILE: rtl/core/efo_pkg.sv
package efo_pkg;

   // Widths of the phase, the tables and the samples.
   localparam int PHASE_BITS     = 32;
   localparam int SINE_ADDR_BITS = 10;
   localparam int EXP_ADDR_BITS  = 8;
   localparam int SAMPLE_BITS    = 16;

   localparam int SINE_DEPTH = (2 ** SINE_ADDR_BITS) + 1;
   localparam int EXP_DEPTH  = 2 ** EXP_ADDR_BITS;

   // Operand width of the shared multiplier.
   localparam int MUL_BITS = 33;

   // Register reset values.
   localparam logic [31:0] BASE_INC_RESET = 32'd2926232;
   localparam logic [15:0] FM_AMT_RESET   = 16'd0;
   localparam logic [15:0] PW_RESET       = 16'd32768;
   localparam logic [15:0] PW_AMT_RESET   = 16'd0;

   // Pulse width clamp limits (0.01 and 0.99 of a cycle).
   localparam logic [15:0] PW_MIN = 16'd655;
   localparam logic [15:0] PW_MAX = 16'd64881;

   // Register indexes.
   localparam logic [7:0] REG_BASE_INC = 8'd0;
   localparam logic [7:0] REG_FM_AMT   = 8'd1;
   localparam logic [7:0] REG_PW       = 8'd2;
   localparam logic [7:0] REG_PW_AMT   = 8'd3;

   typedef logic [31:0]            exp_tab_type  [EXP_DEPTH];
   typedef logic [SAMPLE_BITS-2:0] sine_tab_type [SINE_DEPTH];

   // Integer square root, floor.
   function automatic logic [63:0] isqrt(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = val;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 64'd0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Fractional powers of two in Q2.30, built from repeated square roots of two.
   function automatic exp_tab_type build_exp();
      exp_tab_type tab;
      logic [63:0] roots [EXP_ADDR_BITS+1];
      logic [63:0] p;
      roots[0] = 64'd2 << 30;
      for (int k = 1; k <= EXP_ADDR_BITS; k++) roots[k] = isqrt(roots[k-1] << 30);
      for (int i = 0; i < EXP_DEPTH; i++) begin
         p = 64'd1 << 30;
         for (int b = 0; b < EXP_ADDR_BITS; b++)
            if (((i >> b) & 1) != 0)
               p = (p * roots[EXP_ADDR_BITS-b] + (64'd1 << 29)) >> 30;
         tab[i] = p[31:0];
      end
      return tab;
   endfunction

   // Quarter-wave sine magnitudes from a Taylor series in Q30.
   function automatic sine_tab_type build_sine();
      sine_tab_type tab;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] s;
      logic [63:0] v;
      logic [63:0] one;
      logic [63:0] full;
      one  = 64'd1 << 30;
      full = 64'd1 << (SAMPLE_BITS - 1);
      for (int i = 0; i < SINE_DEPTH; i++) begin
         x  = (64'd1686629713 * 64'(i)) / 64'(2 ** SINE_ADDR_BITS);
         x2 = (x * x) >> 30;
         s  = one;
         for (int k = 8; k >= 1; k--)
            s = one - ((x2 * s) >> 30) / 64'((2 * k) * (2 * k + 1));
         v = (x * s) >> 30;
         v = (v * full + (one >> 1)) >> 30;
         if (v > full - 64'd1) v = full - 64'd1;
         tab[i] = v[SAMPLE_BITS-2:0];
      end
      return tab;
   endfunction

   localparam exp_tab_type  EXP_TAB  = build_exp();
   localparam sine_tab_type SINE_TAB = build_sine();

endpackage

FILE: rtl/core/efo_mul.sv
// Shared signed multiplier with a registered product.
module efo_mul (
   input  logic                                   clock,
   input  logic signed [efo_pkg::MUL_BITS-1:0]    op_a,
   input  logic signed [efo_pkg::MUL_BITS-1:0]    op_b,
   output logic signed [2*efo_pkg::MUL_BITS-1:0]  prod
);

   logic signed [2*efo_pkg::MUL_BITS-1:0] prod_ff;

   // One product per cycle.
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/core/exp_fm_oscillator_with_sync_core.sv
// Each accepted request steps the sequencer from S_FMMUL to S_OUT, where it may wait on an
// output stall; a new request is taken only in S_IDLE. One shared multiplier is used three
// times per request (FM depth, pulse width depth, base increment scaling) by the sequencer.
// The result register holds a finished result while the next request is taken.
// Reset (synchronous, active high) clears the phase, the sync history, the registers
// to their defaults and the control state; tables are constants and need no fill.
module exp_fm_oscillator_with_sync_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // fm_volts[15:0], pw_mod_volts[31:16], pitch_volts[47:32], sync_volts[63:48]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // sine_out[15:0], triangle_out[31:16], saw_out[47:32], square_high[48],
   // pulse_high[49], zero fill [55:50]
   output logic [55:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int PB = efo_pkg::PHASE_BITS;
   localparam int MB = efo_pkg::MUL_BITS;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FMMUL  = 4'd1;
   localparam logic [3:0] S_EXPO   = 4'd2;
   localparam logic [3:0] S_PWID   = 4'd3;
   localparam logic [3:0] S_INCMUL = 4'd4;
   localparam logic [3:0] S_SHIFT  = 4'd5;
   localparam logic [3:0] S_PHASE  = 4'd6;
   localparam logic [3:0] S_SINE   = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   localparam logic [63:0] NYQ64 = 64'd1 << (PB - 1);

   logic [3:0]  state_ff, state_in;

   logic [31:0] base_inc_ff;
   logic [15:0] fm_amt_ff, pw_ff, pw_amt_ff;

   logic signed [15:0] fm_ff, pwv_ff, pitch_ff, sync_ff;
   logic signed [19:0] e_ff;
   logic [15:0]        pwc_ff;
   logic [31:0]        ent_ff;
   logic [PB-1:0]      inc_ff;
   logic [PB-1:0]      phase_ff;
   logic               sync_neg_ff;
   logic [efo_pkg::SINE_ADDR_BITS:0] sidx_ff;
   logic               sneg_ff;
   logic [efo_pkg::SAMPLE_BITS-2:0]  smag_ff;

   logic               rsp_valid_ff;
   logic [55:0]        rsp_data_ff;

   logic signed [MB-1:0]   op_a, op_b;
   logic signed [2*MB-1:0] prod;

   efo_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_FMMUL: begin
            op_a = MB'(fm_ff);
            op_b = MB'(signed'(fm_amt_ff));
         end
         S_EXPO: begin
            op_a = MB'(pwv_ff);
            op_b = MB'(signed'(pw_amt_ff));
         end
         S_INCMUL: begin
            op_a = signed'({1'b0, base_inc_ff});
            op_b = signed'({1'b0, ent_ff});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Exponent, pulse width and increment arithmetic.
   logic signed [19:0] e_in;
   logic signed [24:0] pw_sum;
   logic [15:0]        pwc_in;
   logic signed [7:0]  ip;
   logic signed [9:0]  sh_dn, sh_up;
   logic [63:0]        p, inc64;
   always_comb begin
      e_in   = 20'(pitch_ff) + prod[31:12];
      pw_sum = 25'(signed'({1'b0, pw_ff})) + 25'(signed'(prod[31:8]));
      if (pw_sum < 25'(signed'({1'b0, efo_pkg::PW_MIN})))      pwc_in = efo_pkg::PW_MIN;
      else if (pw_sum > 25'(signed'({1'b0, efo_pkg::PW_MAX}))) pwc_in = efo_pkg::PW_MAX;
      else                                                     pwc_in = pw_sum[15:0];
      ip    = e_ff[19:12];
      sh_dn = 10'sd30 - 10'(ip);
      sh_up = -sh_dn;
      p     = prod[63:0];
      if (!sh_dn[9]) begin
         inc64 = (sh_dn >= 10'sd64) ? 64'd0 : (p >> sh_dn[5:0]);
      end else if (sh_up >= 10'sd32) begin
         inc64 = (p != 64'd0) ? NYQ64 : 64'd0;
      end else if (p > (NYQ64 >> sh_up[4:0])) begin
         inc64 = NYQ64;
      end else begin
         inc64 = p << sh_up[4:0];
      end
      if (inc64 > NYQ64) inc64 = NYQ64;
   end

   // Phase update with hard sync, and waveform shaping.
   logic [PB-1:0]      ph_in;
   logic [1:0]         quad;
   logic [efo_pkg::SINE_ADDR_BITS-1:0] jraw;
   logic [efo_pkg::SINE_ADDR_BITS:0]   sidx_in;
   logic [16:0]        tq;
   logic signed [17:0] tri_v;
   logic [15:0]        tri_o, saw_o, sine_o;
   logic               sq_o, pulse_o;
   always_comb begin
      ph_in = phase_ff + inc_ff;
      if (sync_neg_ff && !sync_ff[15]) ph_in = '0;
      quad = ph_in[PB-1 -: 2];
      jraw = ph_in[PB-3 -: efo_pkg::SINE_ADDR_BITS];
      if (quad[0]) sidx_in = (efo_pkg::SINE_ADDR_BITS+1)'(1 << efo_pkg::SINE_ADDR_BITS)
                             - {1'b0, jraw};
      else         sidx_in = {1'b0, jraw};
      tq = phase_ff[PB-1 -: 17];
      if (tq < 17'd32768)       tri_v = signed'({1'b0, tq});
      else if (tq < 17'd98304)  tri_v = 18'sd65536 - signed'({1'b0, tq});
      else                      tri_v = signed'({1'b0, tq}) - 18'sd131072;
      if (tri_v > 18'sd32767) tri_v = 18'sd32767;
      tri_o   = tri_v[15:0];
      saw_o   = {~phase_ff[PB-1], phase_ff[PB-2 -: 15]};
      sq_o    = ~phase_ff[PB-1];
      pulse_o = (phase_ff[PB-1 -: 16] < pwc_ff);
      sine_o  = sneg_ff ? -{1'b0, smag_ff} : {1'b0, smag_ff};
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_FMMUL;
         S_FMMUL:  state_in = S_EXPO;
         S_EXPO:   state_in = S_PWID;
         S_PWID:   state_in = S_INCMUL;
         S_INCMUL: state_in = S_SHIFT;
         S_SHIFT:  state_in = S_PHASE;
         S_PHASE:  state_in = S_SINE;
         S_SINE:   state_in = S_OUT;
         S_OUT:    if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Control state, configuration and oscillator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_inc_ff  <= efo_pkg::BASE_INC_RESET;
         fm_amt_ff    <= efo_pkg::FM_AMT_RESET;
         pw_ff        <= efo_pkg::PW_RESET;
         pw_amt_ff    <= efo_pkg::PW_AMT_RESET;
         phase_ff     <= '0;
         sync_neg_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               efo_pkg::REG_BASE_INC: base_inc_ff <= csr_data;
               efo_pkg::REG_FM_AMT:   fm_amt_ff   <= csr_data[15:0];
               efo_pkg::REG_PW:       pw_ff       <= csr_data[15:0];
               efo_pkg::REG_PW_AMT:   pw_amt_ff   <= csr_data[15:0];
               default: ;
            endcase
         end
         if (state_ff == S_PHASE) begin
            phase_ff    <= ph_in;
            sync_neg_ff <= sync_ff[15];
         end
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         fm_ff    <= req_tdata[15:0];
         pwv_ff   <= req_tdata[31:16];
         pitch_ff <= req_tdata[47:32];
         sync_ff  <= req_tdata[63:48];
      end
      if (state_ff == S_EXPO)  e_ff <= e_in;
      if (state_ff == S_PWID) begin
         pwc_ff <= pwc_in;
         ent_ff <= efo_pkg::EXP_TAB[e_ff[11 -: efo_pkg::EXP_ADDR_BITS]];
      end
      if (state_ff == S_SHIFT) inc_ff <= inc64[PB-1:0];
      if (state_ff == S_PHASE) begin
         sidx_ff <= sidx_in;
         sneg_ff <= quad[1];
      end
      if (state_ff == S_SINE) smag_ff <= efo_pkg::SINE_TAB[sidx_ff];
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready))
         rsp_data_ff <= {6'd0, pulse_o, sq_o, saw_o, tri_o, sine_o};
   end

   // The sequencer takes no request while one is in progress.
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request accepted while busy");

   // The scaled increment never exceeds Nyquist.
   a_inc_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PHASE) |-> ({32'd0, inc_ff} <= NYQ64))
      else $error("increment above Nyquist");

   // A rising sync crossing restarts the phase at zero.
   a_sync_reset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PHASE && sync_neg_ff && !sync_ff[15]) |=> (phase_ff == '0))
      else $error("sync did not clear the phase");

endmodule

FILE: verif/exp_fm_oscillator_with_sync_core_test.sv
module exp_fm_oscillator_with_sync_core_test;

   localparam logic [7:0]  REG_SPARE  = 8'd9;
   localparam logic [63:0] NYQUIST    = 64'h8000_0000;
   localparam int          QUIET_MAX  = 4000;

   typedef struct packed {
      logic        pulse;
      logic        square;
      logic [15:0] saw;
      logic [15:0] triangle;
      logic [15:0] sine;
   } wave_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [31:0] csr_data;

   // Predictor state and register copies.
   logic [31:0]        phase;
   logic               sync_neg;
   logic [31:0]        base_inc;
   logic signed [15:0] fm_amt;
   logic [15:0]        pw_base;
   logic signed [15:0] pw_amt;
   logic [31:0]        pow2_frac [efo_pkg::EXP_DEPTH];
   logic [14:0]        quarter_sine [efo_pkg::SINE_DEPTH];

   wave_type expected_waves[$];
   int    failures;
   int    quiet_cycles;
   bit    calm;

   exp_fm_oscillator_with_sync_core dut (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Floor square root, one result bit at a time from the top.
   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] cand;
      r = 64'd0;
      for (int b = 31; b >= 0; b--) begin
         cand = r | (64'd1 << b);
         if (cand * cand <= v) r = cand;
      end
      return r;
   endfunction

   // Build the fraction table and the quarter-wave sine table.
   task automatic build_lookups();
      logic [63:0] roots [efo_pkg::EXP_ADDR_BITS+1];
      logic [63:0] p;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] s;
      logic [63:0] v;
      roots[0] = 64'd2 << 30;
      for (int k = 1; k <= efo_pkg::EXP_ADDR_BITS; k++)
         roots[k] = root_floor(roots[k-1] << 30);
      for (int i = 0; i < efo_pkg::EXP_DEPTH; i++) begin
         p = 64'd1 << 30;
         for (int b = 0; b < efo_pkg::EXP_ADDR_BITS; b++)
            if (i[b]) p = (p * roots[efo_pkg::EXP_ADDR_BITS-b] + (64'd1 << 29)) >> 30;
         pow2_frac[i] = p[31:0];
      end
      for (int i = 0; i < efo_pkg::SINE_DEPTH; i++) begin
         x  = (64'd1686629713 * 64'(i)) / 64'd1024;
         x2 = (x * x) >> 30;
         s  = 64'd1 << 30;
         for (int k = 8; k >= 1; k--)
            s = (64'd1 << 30) - ((x2 * s) >> 30) / 64'((2 * k) * (2 * k + 1));
         v = (x * s) >> 30;
         v = (v * 64'd32768 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) v = 64'd32767;
         quarter_sine[i] = v[14:0];
      end
   endtask

   // Advance the oscillator by one sample and return its waveforms.
   function automatic wave_type oscillate(input logic signed [15:0] fmv,
                                          input logic signed [15:0] pwv,
                                          input logic signed [15:0] pitch,
                                          input logic signed [15:0] syncv);
      logic signed [31:0] prod;
      logic signed [31:0] expo;
      logic signed [31:0] octave;
      logic signed [31:0] sh;
      logic signed [31:0] pw;
      logic [63:0]        p;
      logic [63:0]        inc;
      logic [31:0]        ph;
      logic [10:0]        j;
      logic [15:0]        mag;
      logic signed [31:0] t;
      logic signed [31:0] triv;
      wave_type           w;
      prod   = fmv * fm_amt;
      expo   = pitch + (prod >>> 12);
      octave = expo >>> 12;
      p      = {32'd0, base_inc} * {32'd0, pow2_frac[expo[11:4]]};
      if (octave <= 30) begin
         sh  = 30 - octave;
         inc = (sh >= 64) ? 64'd0 : (p >> sh);
      end else begin
         sh = octave - 30;
         if (sh >= 32) inc = (p == 64'd0) ? 64'd0 : NYQUIST;
         else if (p > (NYQUIST >> sh)) inc = NYQUIST;
         else inc = p << sh;
      end
      if (inc > NYQUIST) inc = NYQUIST;

      prod = pwv * pw_amt;
      pw   = $signed({16'd0, pw_base}) + (prod >>> 8);
      if (pw < $signed({16'd0, efo_pkg::PW_MIN})) pw = {16'd0, efo_pkg::PW_MIN};
      if (pw > $signed({16'd0, efo_pkg::PW_MAX})) pw = {16'd0, efo_pkg::PW_MAX};

      // A rising zero crossing of sync restarts the cycle.
      ph = phase + inc[31:0];
      if (sync_neg && !syncv[15]) ph = 32'd0;
      phase    = ph;
      sync_neg = syncv[15];

      j = {1'b0, ph[29:20]};
      if (ph[30]) j = 11'd1024 - j;
      mag    = {1'b0, quarter_sine[j]};
      w.sine = ph[31] ? -mag : mag;

      t = {15'd0, ph[31:15]};
      if (t < 32768) triv = t;
      else if (t < 3 * 32768) triv = 65536 - t;
      else triv = t - 4 * 32768;
      if (triv > 32767) triv = 32767;
      w.triangle = triv[15:0];

      w.saw    = {~ph[31], ph[30:16]};
      w.square = ~ph[31];
      w.pulse  = ({16'd0, ph[31:16]} < pw);
      return w;
   endfunction

   // Wait until every predicted sample has come back, then let the pipeline settle.
   task automatic wait_drained();
      while (expected_waves.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // Random gap before a handshake.
   task automatic maybe_idle(ref logic valid);
      if (!calm && $urandom_range(99) < 20) begin
         valid = 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
   endtask

   // Write one register while the oscillator is idle.
   task automatic write_reg(input logic [7:0] index, input logic [31:0] value);
      wait_drained();
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         efo_pkg::REG_BASE_INC: base_inc = value;
         efo_pkg::REG_FM_AMT:   fm_amt   = value[15:0];
         efo_pkg::REG_PW:       pw_base  = value[15:0];
         efo_pkg::REG_PW_AMT:   pw_amt   = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Send one sample request and queue its predicted waveforms.
   task automatic send_sample(input logic [15:0] fmv, input logic [15:0] pwv,
                              input logic [15:0] pitch, input logic [15:0] syncv);
      maybe_idle(req_tvalid);
      req_tvalid = 1'b1;
      req_tdata  = {syncv, pitch, pwv, fmv};
      do @(posedge clock); while (!req_tready);
      expected_waves.push_back(oscillate(fmv, pwv, pitch, syncv));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_random_sample();
      logic [15:0] pitch;
      logic [15:0] syncv;
      // Mostly musical pitches, sometimes the whole range.
      pitch = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16'h7FFF, 0));
      pitch = ($urandom_range(1) == 0) ? pitch : 16'(16'h0 - {1'b0, pitch[14:0]});
      syncv = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(16'h7FFF, 0));
      if ($urandom_range(9) == 0) syncv = 16'h8000 | syncv;
      send_sample(16'($urandom), 16'($urandom), pitch, syncv);
   endtask

   // Reset registers with extreme pitches, fields and sync edges.
   task automatic test_directed_defaults();
      send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
      send_sample(16'hFFFF, 16'hFFFF, 16'h5000, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'h4000, 16'hFFFF);
      send_sample(16'h0000, 16'h0000, 16'h4000, 16'h0001);
      send_sample(16'h0000, 16'h0000, 16'h6FF0, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'h7000, 16'h0000);
   endtask

   // Extreme register settings: Nyquist clamps, zero base, pulse width clamps.
   task automatic test_extreme_registers();
      write_reg(efo_pkg::REG_BASE_INC, 32'h0000_0000);
      send_sample(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
      write_reg(efo_pkg::REG_BASE_INC, 32'h8000_0000);
      write_reg(efo_pkg::REG_FM_AMT, 32'h0000_7FFF);
      write_reg(efo_pkg::REG_PW, 32'h0000_0000);
      write_reg(efo_pkg::REG_PW_AMT, 32'h0000_7FFF);
      send_sample(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000);
      send_sample(16'h8000, 16'h8000, 16'h0000, 16'h8000);
      send_sample(16'h0000, 16'h0000, 16'h1000, 16'h0000);
      write_reg(efo_pkg::REG_FM_AMT, 32'h0000_8000);
      write_reg(efo_pkg::REG_PW, 32'h0000_FFFF);
      write_reg(efo_pkg::REG_PW_AMT, 32'h0000_8000);
      send_sample(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000);
      send_sample(16'h8000, 16'h8000, 16'h0000, 16'h0000);
      write_reg(efo_pkg::REG_BASE_INC, 32'h0001_0000);
      write_reg(efo_pkg::REG_FM_AMT, 32'h0000_1000);
      send_sample(16'h0000, 16'h0000, 16'h7000, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'h8000, 16'h0000);
      // A write to an unknown index changes nothing.
      write_reg(REG_SPARE, 32'hFFFF_FFFF);
      send_sample(16'h1234, 16'h4321, 16'h0800, 16'h0000);
   endtask

   // Random register settings, each followed by a burst of random samples.
   task automatic test_random_phases();
      for (int phase_no = 0; phase_no < 12; phase_no++) begin
         write_reg(efo_pkg::REG_BASE_INC,
                   ($urandom_range(3) == 0) ? $urandom_range(32'h8000_0000, 0)
                                            : $urandom_range(32'h0100_0000, 0));
         write_reg(efo_pkg::REG_FM_AMT,
                   $urandom_range(3) == 0 ? 32'($urandom)
                                          : 32'($urandom_range(16'h1FFF, 0)));
         write_reg(efo_pkg::REG_PW, $urandom);
         write_reg(efo_pkg::REG_PW_AMT, $urandom);
         calm = (phase_no == 5);
         for (int n = 0; n < 150; n++) begin
            send_random_sample();
            if (phase_no == 3 && n == 70) begin
               req_tvalid = 1'b0;
               wait_drained();
            end
         end
         calm = 1'b0;
      end
   endtask

   // Result side: random backpressure and field-by-field comparison.
   always @(negedge clock) rsp_tready <= calm || ($urandom_range(99) >= 20);

   always @(posedge clock) begin
      wave_type want;
      wave_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[49:0];
         if (expected_waves.size() == 0) begin
            $display("%0t: unexpected sample, got %h", $time, got);
            failures++;
         end else begin
            want = expected_waves.pop_front();
            if (got.sine !== want.sine) begin
               $display("%0t: sine expected %h actual %h", $time, want.sine, got.sine);
               failures++;
            end
            if (got.triangle !== want.triangle) begin
               $display("%0t: triangle expected %h actual %h", $time, want.triangle,
                        got.triangle);
               failures++;
            end
            if (got.saw !== want.saw) begin
               $display("%0t: saw expected %h actual %h", $time, want.saw, got.saw);
               failures++;
            end
            if (got.square !== want.square) begin
               $display("%0t: square expected %b actual %b", $time, want.square, got.square);
               failures++;
            end
            if (got.pulse !== want.pulse) begin
               $display("%0t: pulse expected %b actual %b", $time, want.pulse, got.pulse);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 64'd0;
      rsp_tready   = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = 8'd0;
      csr_data     = 32'd0;
      failures     = 0;
      quiet_cycles = 0;
      calm         = 1'b0;
      phase        = 32'd0;
      sync_neg     = 1'b0;
      base_inc     = efo_pkg::BASE_INC_RESET;
      fm_amt       = efo_pkg::FM_AMT_RESET;
      pw_base      = efo_pkg::PW_RESET;
      pw_amt       = efo_pkg::PW_AMT_RESET;
      build_lookups();
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_directed_defaults();
      test_extreme_registers();
      test_random_phases();

      req_tvalid = 1'b0;
      while (expected_waves.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/efo_pkg.sv
rtl/core/efo_mul.sv
rtl/core/exp_fm_oscillator_with_sync_core.sv
verif/exp_fm_oscillator_with_sync_core_test.sv
